FILE: sv/integer_set_sorter_assert.svh
// Assertion macros for the integer set sorter checker.
`ifndef INTEGER_SET_SORTER_ASSERT_SVH
`define INTEGER_SET_SORTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ISS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ISS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/iss_pkg.sv
// Package: shared constants, state type and emit-load struct of the set sorter.
package iss_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_EMIT
  } iss_state_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
    logic              last;
    logic              ovf;
  } iss_load_t;

endpackage

FILE: sv/iss_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
module iss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/iss_ctrl.sv
// Controller: insertion into the RAM on load, sequential RAM readout on emit.
module iss_ctrl import iss_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_value,
  input  logic              in_last,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [DATA_W-1:0] ram_wdata,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  logic [DATA_W-1:0] ram_rdata,
  input  logic              out_free,
  output iss_load_t         load
);

  iss_state_t        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              rd_last_r, rd_last_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic              last_pend_r, last_pend_nxt;
  logic [AW-1:0]     emit_idx_r, emit_idx_nxt;

  logic in_acc;
  logic has_room;
  logic key_less;
  logic issue;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign has_room = (count_r < CW'(DEPTH));
  assign key_less = ($signed(key_r) < $signed(ram_rdata));
  assign issue    = (state_r == ST_EMIT) && !rd_pend_r && out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (has_room && (count_r != '0)) begin
            state_nxt = ST_SHIFT;
          end else if (in_last) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_SHIFT: begin
        if (key_less) begin
          if (pos_r == AW'(1)) begin
            state_nxt = ST_PLACE;
          end
        end else begin
          state_nxt = last_pend_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_PLACE: begin
        state_nxt = last_pend_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (rd_pend_r && rd_last_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, RAM controls and readout
  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    last_pend_nxt = last_pend_r;
    emit_idx_nxt  = (state_r == ST_EMIT) ? emit_idx_r : '0;
    rd_pend_nxt   = issue;
    rd_last_nxt   = rd_last_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = key_r;
    ram_re        = 1'b0;
    ram_raddr     = pos_r - 1'b1 - 1'b1;
    load.valid    = rd_pend_r;
    load.data     = ram_rdata;
    load.last     = rd_last_r;
    load.ovf      = ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          key_nxt       = in_value;
          last_pend_nxt = in_last;
          pos_nxt       = count_r[AW-1:0];
          if (!has_room) begin
            // store full: drop the value
            ovf_nxt = 1'b1;
          end else if (count_r == '0) begin
            // empty store: place directly
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = in_value;
            count_nxt = count_r + 1'b1;
          end else begin
            // fetch the current tail to start the walk
            ram_re    = 1'b1;
            ram_raddr = AW'(count_r - 1'b1);
          end
        end
      end
      ST_SHIFT: begin
        ram_we = 1'b1;
        if (key_less) begin
          // move the larger entry up one slot and, unless it came from slot 0, look one further down
          ram_wdata = ram_rdata;
          pos_nxt   = pos_r - 1'b1;
          ram_re    = (pos_r != AW'(1));
        end else begin
          ram_wdata = key_r;
          count_nxt = count_r + 1'b1;
        end
      end
      ST_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = key_r;
        count_nxt = count_r + 1'b1;
      end
      ST_EMIT: begin
        if (issue) begin
          ram_re       = 1'b1;
          ram_raddr    = emit_idx_r;
          rd_last_nxt  = ((CW'(emit_idx_r) + CW'(1)) == count_r);
          emit_idx_nxt = emit_idx_r + 1'b1;
        end
        if (rd_pend_r && rd_last_r) begin
          // set handed off: clear for the next one
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      ovf_r     <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      ovf_r     <= ovf_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    pos_r       <= pos_nxt;
    last_pend_r <= last_pend_nxt;
    emit_idx_r  <= emit_idx_nxt;
    rd_last_r   <= rd_last_nxt;
  end

endmodule

FILE: sv/iss_out.sv
// Output register: holds one result item until the receiver takes it.
module iss_out import iss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  iss_load_t         load,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data,
  output logic              out_last,
  output logic              out_ovf
);

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] data_r;
  logic              last_r;
  logic              ovf_r;

  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_last  = last_r;
  assign out_ovf   = ovf_r;

  // Fill on load, drain on handshake
  always_comb begin
    valid_nxt = valid_r;
    if (load.valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      data_r <= load.data;
      last_r <= load.last;
      ovf_r  <= load.ovf;
    end
  end

endmodule

FILE: sv/integer_set_sorter.sv
// Top level: sorts a set of signed 32-bit values and streams them back ascending.
//
// Input channel in_*: one signed value per item in in_tdata; in_tlast marks the
// final value of the set, which is itself a member. Output channel out_*: the
// stored values in ascending order, duplicates kept, out_tlast on the final one
// and out_tuser set on every result when values were dropped for lack of room.
// Up to DEPTH values are kept in one RAM; further values are dropped.
// Loading is an insertion sort in the RAM: an item into an empty store is
// written directly, one that finds no room is dropped, and otherwise the walk
// goes down the sorted entries with one RAM read and one write per cycle,
// moving each larger entry up one slot, with a final write when the item goes
// to slot 0. After the final item is placed, each result is read from the RAM
// into the output register; the next read waits until that result is loaded.
// The next set's first item is taken as soon as the final result sits in the
// output register. A receiver stall holds the output register and pauses the
// readout; nothing is lost. Reset (rst_n low, synchronous) empties the set and
// clears the overflow flag; RAM contents are not cleared and need not be.
module integer_set_sorter import iss_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [31:0] value
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [31:0] sorted_value
  output logic              out_tlast,
  output logic [0:0]        out_tuser   // [0] overflow
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic              out_free;
  iss_load_t         load;

  iss_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_value  (in_tdata),
    .in_last   (in_tlast),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_free  (out_free),
    .load      (load)
  );

  iss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  iss_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .out_free  (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .out_ovf   (out_tuser[0])
  );

endmodule

FILE: sv/iss_checker.sv
// Checker on the sorter's ports, bound to the top level.
`include "integer_set_sorter_assert.svh"

module iss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic [0:0]  out_tuser
);

  // Stalled result holds its value
  `ISS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // No new input while a set is still being read out
  `ISS_ASSERT_SAME(a_no_load_mid_emit, out_tvalid && !out_tlast, !in_tready, "input taken during readout")

  // Overflow flag is the same on every result of a set
  `ISS_ASSERT_NEXT(a_ovf_steady, out_tvalid && out_tready && !out_tlast, !out_tvalid || (out_tuser == $past(out_tuser)), "overflow flag changed inside a set")

  // Closing item of a set starts work, so no input is taken next cycle
  `ISS_ASSERT_NEXT(a_busy_after_last, in_tvalid && in_tready && in_tlast, !in_tready, "input taken right after final item")

endmodule

bind integer_set_sorter iss_checker u_iss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
